FILE: rtl/mvt_pkg.sv
// Shared types, constants and the saturation function for the 4x4 matrix-vector transform.
// No dependencies; every other RTL file uses this package.
package mvt_pkg;

    localparam int LANES     = 4;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int TDATA_W   = LANES * DATA_W;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_word                    t_vec [LANES];
    typedef t_sum                     t_sum_vec [LANES];
    typedef logic [CFG_W-1:0]         t_cfg_reg;
    typedef t_cfg_reg                 t_cfg_file [NUM_REGS];

    // Pipeline control handed to the merge stage.
    typedef struct packed {
        logic adv;
        logic vld;
    } t_stage_ctl;

    // Identity matrix: 1.0 in Q16.16 on the diagonal.
    localparam t_cfg_reg COEF_RST [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    localparam t_sum SAT_MAX = t_sum'(64'sh0000_0000_7FFF_FFFF);
    localparam t_sum SAT_MIN = t_sum'(-64'sh0000_0000_8000_0000);

    // Clamps a wide row sum to the signed 32-bit range.
    function automatic t_word sat32(input t_sum v);
        t_word r;
        if (v > SAT_MAX) begin
            r = t_word'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = t_word'(SAT_MIN);
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/mvt_lane.sv
// One row lane: four products, pairwise sums, then the full row sum, each stage registered.
// Depends on mvt_pkg.
module mvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  mvt_pkg::t_vec i_coef,
    input  mvt_pkg::t_vec i_vec,
    output mvt_pkg::t_sum o_sum
);
    import mvt_pkg::*;

    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [PROD_W-1:0] w_term [LANES];
    logic signed [PAIR_W-1:0] r_pair [2];
    t_sum                     r_sum;

    // Arithmetic shift rounds each product toward minus infinity.
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            w_term[c] = r_prod[c] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < LANES; c++) begin
                r_prod[c] <= PROD_W'(i_coef[c]) * PROD_W'(i_vec[c]);
            end
            r_pair[0] <= PAIR_W'(w_term[0]) + PAIR_W'(w_term[1]);
            r_pair[1] <= PAIR_W'(w_term[2]) + PAIR_W'(w_term[3]);
            r_sum     <= SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: rtl/mvt_merge.sv
// Merge stage: saturates the four lane sums and holds the result vector for the output.
// Depends on mvt_pkg.
module mvt_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mvt_pkg::t_stage_ctl i_ctl,
    input  mvt_pkg::t_sum_vec   i_sums,
    output logic                o_valid,
    output mvt_pkg::t_vec       o_data
);
    import mvt_pkg::*;

    logic  r_valid;
    t_vec  r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_data[l] <= sat32(i_sums[l]);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/matrix4_vector_transform.sv
// Path of an input transfer to the output: products, pair sums, row sums, then saturation into
// the output register. Throughput: one vector per cycle while the output is not stalled, set by
// the four row lanes each with four 32x32 multipliers working in parallel.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// Depends on mvt_pkg, mvt_lane and mvt_merge.
module matrix4_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input vector: in_x [31:0], in_y [63:32], in_z [95:64], in_w [127:96].
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mvt_pkg::TDATA_W-1:0]         i_s_axis_tdata,
    // Result vector: out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96].
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mvt_pkg::TDATA_W-1:0]         o_m_axis_tdata,
    // Coefficient register writes.
    input  logic                                i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mvt_pkg::CFG_W-1:0]           i_cfg_data
);
    import mvt_pkg::*;

    t_cfg_file  r_coef;
    t_vec       w_vec;
    t_vec       w_rows [LANES];
    t_sum_vec   w_sums;
    t_vec       w_out;
    t_stage_ctl w_ctl;
    logic       w_adv;
    logic       w_out_valid;
    // Valid flags for the product, pair-sum and row-sum stages of the lanes.
    logic       r_vld_p;
    logic       r_vld_s;
    logic       r_vld_t;

    // The whole pipeline moves together whenever the output register is free or being
    // drained in this cycle, so a new transfer is taken every cycle while the sink keeps up.
    assign w_adv           = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // Coefficient registers. Each holds two Q16.16 entries, the even one in the low half.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Unpack the input vector and spread the matrix into rows for the lanes.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_vec[i] = i_s_axis_tdata[i*DATA_W +: DATA_W];
        end
        for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
                w_rows[r][c] = r_coef[(r*LANES + c) / 2][((r*LANES + c) % 2)*DATA_W +: DATA_W];
            end
        end
    end

    // Track which pipeline slots hold a real item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
            r_vld_s <= 1'b0;
            r_vld_t <= 1'b0;
        end else if (w_adv) begin
            r_vld_p <= i_s_axis_tvalid;
            r_vld_s <= r_vld_p;
            r_vld_t <= r_vld_s;
        end
    end

    // One lane per matrix row; each produces the unsaturated row sum of its floored products.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_coef (w_rows[l]),
            .i_vec  (w_vec),
            .o_sum  (w_sums[l])
        );
    end

    assign w_ctl.adv = w_adv;
    assign w_ctl.vld = r_vld_t;

    // Saturation and the output register.
    mvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sums  (w_sums),
        .o_valid (w_out_valid),
        .o_data  (w_out)
    );

    assign o_m_axis_tvalid = w_out_valid;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            o_m_axis_tdata[i*DATA_W +: DATA_W] = w_out[i];
        end
    end

endmodule

FILE: rtl/mvt_check.sv
// Port-level checker for the matrix-vector transform, bound to the top level.
// Depends on mvt_pkg and matrix4_vector_transform.
module mvt_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [mvt_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic                        i_cfg_we,
    input logic [mvt_pkg::CFG_IDX_W-1:0] i_cfg_idx
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // With no result waiting, the block always takes input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output");

    // An accepted vector reaches the output through the lane and output registers when the sink keeps up.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready ##1 i_m_axis_tready
        ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // Configuration is write-only and not observed here beyond being driven.
    a_cfg_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !$isunknown(i_cfg_idx))
        else $error("configuration write with unknown index");

endmodule

bind matrix4_vector_transform mvt_check u_mvt_check (.*);

FILE: tb/matrix4_vector_transform_tb.sv
// Self-checking testbench for matrix4_vector_transform: streams Q16.16 vectors through the
// block under several coefficient matrices and checks every result against a local predictor.
// Depends on mvt_pkg and the RTL of matrix4_vector_transform; needs no other files.
module matrix4_vector_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int FRAC       = 16;
    localparam int PIPE_DEPTH = 4;
    localparam int RAND_SETS  = 9;
    localparam int SET_ITEMS  = 210;
    localparam int TIMEOUT_NS = 2_000_000;

    // Row sums are carried in 66 bits, wide enough for four shifted 64-bit products.
    localparam logic signed [65:0] ROW_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] ROW_MIN = -66'sh0_8000_0000;

    localparam t_word EDGE_WORDS [7] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000,
        32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    // Field order matches the tdata layout: x in the lowest 32 bits, w in the highest.
    typedef struct packed {
        t_word w;
        t_word z;
        t_word y;
        t_word x;
    } t_vec4;

    typedef enum int {
        WORD_FULL,
        WORD_SMALL,
        WORD_EDGE,
        WORD_MIXED
    } t_word_kind;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_s_axis_tvalid  = 1'b0;
    logic                 o_s_axis_tready;
    // Fields from bit 0 up: in_x, in_y, in_z, in_w.
    logic [TDATA_W-1:0]   i_s_axis_tdata   = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready  = 1'b0;
    // Fields from bit 0 up: out_x, out_y, out_z, out_w.
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic [CFG_W-1:0]     i_cfg_data       = '0;

    // Copy of the coefficient registers as the block should hold them.
    t_cfg_file coef_shadow = COEF_RST;

    t_vec4 vector_queue [$];
    t_vec4 expected_results [$];

    int  n_queued     = 0;
    int  n_accepted   = 0;
    int  n_results    = 0;
    int  n_saturated  = 0;
    int  n_settings   = 1;
    int  n_errors     = 0;
    bit  idle_on      = 1'b1;
    bit  in_fire      = 1'b0;
    int  gap_left     = 0;
    int  stall_left   = 0;

    matrix4_vector_transform #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Matrix entry e sits in register e/2, the even entry in the low half.
    function automatic t_word matrix_entry(int e);
        t_cfg_reg r;
        r = coef_shadow[e / 2];
        return (e % 2) ? t_word'(r[63:32]) : t_word'(r[31:0]);
    endfunction

    // Each product is exact in 64 bits, then floored by the arithmetic shift. The four terms
    // are summed exactly and the row sum is clamped to the signed 32-bit range.
    function automatic t_vec4 transform_vector(t_vec4 v);
        t_vec4             r;
        t_word             comp [4];
        t_word             row_out [4];
        logic signed [63:0] c64;
        logic signed [63:0] v64;
        logic signed [63:0] prod;
        logic signed [65:0] acc;
        comp = '{v.x, v.y, v.z, v.w};
        for (int row = 0; row < 4; row++) begin
            acc = '0;
            for (int col = 0; col < 4; col++) begin
                c64  = matrix_entry(row * 4 + col);
                v64  = comp[col];
                prod = c64 * v64;
                acc  = acc + (prod >>> FRAC);
            end
            if (acc > ROW_MAX) begin
                row_out[row] = 32'h7FFF_FFFF;
            end else if (acc < ROW_MIN) begin
                row_out[row] = 32'h8000_0000;
            end else begin
                row_out[row] = acc[31:0];
            end
        end
        r.x = row_out[0];
        r.y = row_out[1];
        r.z = row_out[2];
        r.w = row_out[3];
        return r;
    endfunction

    function automatic t_word pick_word(t_word_kind kind);
        t_word w;
        case (kind)
            WORD_FULL: begin
                w = $urandom;
            end
            WORD_SMALL: begin
                // Roughly plus or minus 16.0, so sums mostly stay in range.
                w = t_word'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            end
            WORD_EDGE: begin
                w = EDGE_WORDS[$urandom_range(0, 6)];
            end
            default: begin
                w = pick_word(t_word_kind'($urandom_range(WORD_FULL, WORD_EDGE)));
            end
        endcase
        return w;
    endfunction

    function automatic t_cfg_reg pair(t_word lo, t_word hi);
        return {hi, lo};
    endfunction

    function automatic void enqueue(t_word x, t_word y, t_word z, t_word w);
        t_vec4 v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.w = w;
        vector_queue.push_back(v);
        n_queued++;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // Writes all eight registers on consecutive cycles; called only while the block is idle.
    task automatic load_matrix(t_cfg_file m);
        for (int i = 0; i < NUM_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we       <= 1'b1;
            i_cfg_idx      <= CFG_IDX_W'(i);
            i_cfg_data     <= m[i];
            coef_shadow[i]  = m[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Waits until every queued vector was taken and every result came back, then lets the
    // pipeline settle for a few more cycles.
    task automatic drain();
        while (n_accepted != n_queued || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    // Sender: one item per transfer, with random bursts of empty cycles while idling is on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 15);
                i_s_axis_tvalid <= 1'b0;
            end else if (vector_queue.size() > 0) begin
                i_s_axis_tdata  <= vector_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready most of the time, with random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer lane by lane.
    always @(posedge i_clk) begin
        logic [TDATA_W-1:0] got;
        logic [TDATA_W-1:0] want;
        string              lane_name [4];
        lane_name = '{"out_x", "out_y", "out_z", "out_w"};
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(transform_vector(t_vec4'(i_s_axis_tdata)));
                n_accepted++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no vector outstanding", got));
                end else begin
                    want = expected_results.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[32*i +: 32] !== want[32*i +: 32]) begin
                            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                n_results, lane_name[i], got[32*i +: 32], want[32*i +: 32]));
                        end
                        if (want[32*i +: 32] == 32'h7FFF_FFFF ||
                                want[32*i +: 32] == 32'h8000_0000) begin
                            n_saturated++;
                        end
                    end
                end
                n_results++;
            end
        end
    end

    initial begin
        t_cfg_file  m;
        t_word_kind coef_kind;
        t_word_kind vec_kind;
        int         pick;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset matrix is the identity: values pass through unchanged, extremes included.
        enqueue(32'h0, 32'h0, 32'h0, 32'h0);
        enqueue(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        enqueue(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        enqueue(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        enqueue(32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_0000);
        drain();

        // Largest positive coefficients: sums overflow in both directions.
        foreach (m[i]) m[i] = pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_matrix(m);
        enqueue(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        enqueue(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        enqueue(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        enqueue(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Most negative coefficients: min times min is the largest product there is.
        foreach (m[i]) m[i] = pair(32'h8000_0000, 32'h8000_0000);
        load_matrix(m);
        enqueue(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        enqueue(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // Coefficients of one negative LSB: tiny negative products floor to -1, not 0.
        foreach (m[i]) m[i] = '1;
        load_matrix(m);
        enqueue(32'h1, 32'h1, 32'h1, 32'h1);
        enqueue(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        enqueue(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        drain();

        // All-zero matrix.
        foreach (m[i]) m[i] = '0;
        load_matrix(m);
        enqueue(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // Row sums landing exactly on and just past the saturation bounds.
        foreach (m[i]) m[i] = '0;
        m[0] = pair(32'h0001_0000, 32'h0001_0000);
        m[2] = pair(32'hFFFF_0000, 32'hFFFF_0000);
        m[5] = pair(32'h0001_0000, 32'h0);
        m[7] = pair(32'h0, 32'h0001_0000);
        load_matrix(m);
        enqueue(32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0);
        enqueue(32'h7FFF_FFFE, 32'h1, 32'h0, 32'h0);
        enqueue(32'h7FFF_FFFF, 32'h2, 32'h0, 32'h0);
        drain();

        // Random matrices and vectors; the final set runs with both sides always ready.
        for (int p = 0; p < RAND_SETS; p++) begin
            idle_on = (p < RAND_SETS - 1);
            case (p % 3)
                0: coef_kind = WORD_SMALL;
                1: coef_kind = WORD_FULL;
                default: coef_kind = WORD_MIXED;
            endcase
            foreach (m[i]) m[i] = pair(pick_word(coef_kind), pick_word(coef_kind));
            load_matrix(m);
            for (int n = 0; n < SET_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    vec_kind = WORD_SMALL;
                end else if (pick < 17) begin
                    vec_kind = WORD_FULL;
                end else begin
                    vec_kind = WORD_MIXED;
                end
                enqueue(pick_word(vec_kind), pick_word(vec_kind),
                        pick_word(vec_kind), pick_word(vec_kind));
            end
            drain();
        end

        $display("Sent %0d vectors under %0d coefficient settings; checked %0d results.",
                 n_queued, n_settings, n_results);
        $display("Saturated lanes expected: %0d; mismatches: %0d.", n_saturated, n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Safety net in case the handshake hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
